// File: rtl/rgbled_pkg.sv
// ----------------------------------------------------------------------------
// rgbled_pkg
// Shared types, constants and helpers for the single-wire RGB LED encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbled_pkg;

  // Frame layout: header byte, then green, red and blue.
  localparam int          FRAME_BITS  = 32;
  localparam int          BITS_W      = $clog2(FRAME_BITS + 1);
  localparam logic [7:0]  FRAME_HDR   = 8'h3A;

  localparam int          TICK_W      = 12;
  localparam int          SHORT_W     = 8;

  // Configuration port
  localparam int          CFG_IDX_W   = 3;
  localparam int          CFG_DATA_W  = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_TICKS    = 3'd0,
    CFG_ONE_GAP_TICKS  = 3'd1,
    CFG_ONE_TAIL_TICKS = 3'd2,
    CFG_ZERO_GAP_TICKS = 3'd3,
    CFG_LATCH_TICKS    = 3'd4
  } cfg_idx_t;

  localparam logic [SHORT_W-1:0] PULSE_TICKS_RST    = 8'd1;
  localparam logic [SHORT_W-1:0] ONE_GAP_TICKS_RST  = 8'd10;
  localparam logic [SHORT_W-1:0] ONE_TAIL_TICKS_RST = 8'd78;
  localparam logic [SHORT_W-1:0] ZERO_GAP_TICKS_RST = 8'd90;
  localparam logic [TICK_W-1:0]  LATCH_TICKS_RST    = 12'd800;

  // Request types
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PULSE1 = 3'd1,
    PH_GAP1   = 3'd2,
    PH_PULSE2 = 3'd3,
    PH_TAIL   = 3'd4,
    PH_ZGAP   = 3'd5,
    PH_LATCH  = 3'd6
  } phase_t;

  // A duration of zero is stretched to one tick.
  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    at_least_one = (v == '0) ? TICK_W'(1) : v;
  endfunction

  function automatic logic is_busy(input phase_t ph);
    is_busy = (ph >= PH_PULSE1) && (ph <= PH_LATCH);
  endfunction

endpackage

`default_nettype wire

// File: rtl/rgbled_if.sv
// ----------------------------------------------------------------------------
// rgbled_in_if / rgbled_out_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbled_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output req_type, output red, output green,
                  output blue, input ready);
  modport sink   (input valid, input req_type, input red, input green,
                  input blue, output ready);
endinterface

interface rgbled_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic load_rejected;

  modport source (output valid, output pin_level, output busy_res,
                  output load_rejected, input ready);
  modport sink   (input valid, input pin_level, input busy_res,
                  input load_rejected, output ready);
endinterface

`default_nettype wire

// File: rtl/rgb_led_one_wire_encoder_top.sv
// ----------------------------------------------------------------------------
// rgb_led_one_wire_encoder_top
// A result word is valid in the cycle after its request word is taken.
// Throughput: one request word per cycle; the result register drains while
// the next word is taken, so the rate is set only by the output consumer.
// Reset: synchronous, active low; timing registers return to their defaults,
// the line goes low and the encoder is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_one_wire_encoder_top (
  input  wire                               clk,
  input  wire                               rst_n,
  rgbled_in_if.sink                         in_ch,
  rgbled_out_if.source                      out_ch,
  input  wire                               cfg_we,
  input  wire [rgbled_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [rgbled_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rgbled_pkg::*;

  // Timing registers
  logic [SHORT_W-1:0] pulse_ticks_r;
  logic [SHORT_W-1:0] one_gap_ticks_r;
  logic [SHORT_W-1:0] one_tail_ticks_r;
  logic [SHORT_W-1:0] zero_gap_ticks_r;
  logic [TICK_W-1:0]  latch_ticks_r;

  // Waveform state
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [BITS_W-1:0]     bits_left_r, bits_left_nxt;
  phase_t                phase_r, phase_nxt;
  logic [TICK_W-1:0]     tick_r, tick_nxt;
  logic                  line_r, line_nxt;

  // Result register
  logic out_valid_r;
  logic pin_level_r;
  logic busy_r;
  logic rejected_r;
  logic rejected;

  logic              in_acc;
  logic [TICK_W-1:0] tick_dec;
  logic [BITS_W-1:0] bits_dec;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pin_level     = pin_level_r;
  assign out_ch.busy_res      = busy_r;
  assign out_ch.load_rejected = rejected_r;

  assign tick_dec = tick_r - TICK_W'(1);
  assign bits_dec = bits_left_r - BITS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r    <= PULSE_TICKS_RST;
      one_gap_ticks_r  <= ONE_GAP_TICKS_RST;
      one_tail_ticks_r <= ONE_TAIL_TICKS_RST;
      zero_gap_ticks_r <= ZERO_GAP_TICKS_RST;
      latch_ticks_r    <= LATCH_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PULSE_TICKS:    pulse_ticks_r    <= cfg_data[SHORT_W-1:0];
        CFG_ONE_GAP_TICKS:  one_gap_ticks_r  <= cfg_data[SHORT_W-1:0];
        CFG_ONE_TAIL_TICKS: one_tail_ticks_r <= cfg_data[SHORT_W-1:0];
        CFG_ZERO_GAP_TICKS: zero_gap_ticks_r <= cfg_data[SHORT_W-1:0];
        CFG_LATCH_TICKS:    latch_ticks_r    <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    frame_nxt     = frame_r;
    bits_left_nxt = bits_left_r;
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    line_nxt      = line_r;
    rejected      = 1'b0;
    if (in_acc) begin
      if (in_ch.req_type == REQ_LOAD) begin
        if (is_busy(phase_r)) begin
          rejected = 1'b1;
        end else begin
          frame_nxt     = {FRAME_HDR, in_ch.green, in_ch.red, in_ch.blue};
          bits_left_nxt = BITS_W'(FRAME_BITS);
          phase_nxt     = PH_PULSE1;
          tick_nxt      = at_least_one(TICK_W'(pulse_ticks_r));
          line_nxt      = 1'b1;
        end
      end else if (is_busy(phase_r)) begin
        tick_nxt = tick_dec;
        if (tick_dec == '0) begin
          unique case (phase_r)
            PH_PULSE1: begin
              line_nxt = 1'b0;
              if (frame_r[FRAME_BITS-1]) begin
                phase_nxt = PH_GAP1;
                tick_nxt  = at_least_one(TICK_W'(one_gap_ticks_r));
              end else begin
                phase_nxt = PH_ZGAP;
                tick_nxt  = at_least_one(TICK_W'(zero_gap_ticks_r));
              end
            end
            PH_GAP1: begin
              phase_nxt = PH_PULSE2;
              tick_nxt  = at_least_one(TICK_W'(pulse_ticks_r));
              line_nxt  = 1'b1;
            end
            PH_PULSE2: begin
              phase_nxt = PH_TAIL;
              tick_nxt  = at_least_one(TICK_W'(one_tail_ticks_r));
              line_nxt  = 1'b0;
            end
            PH_TAIL, PH_ZGAP: begin
              // End of a bit cell: move to the next bit or to the latch gap.
              frame_nxt     = {frame_r[FRAME_BITS-2:0], 1'b0};
              bits_left_nxt = bits_dec;
              if (bits_dec != '0) begin
                phase_nxt = PH_PULSE1;
                tick_nxt  = at_least_one(TICK_W'(pulse_ticks_r));
                line_nxt  = 1'b1;
              end else begin
                phase_nxt = PH_LATCH;
                tick_nxt  = at_least_one(latch_ticks_r);
                line_nxt  = 1'b0;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
              tick_nxt  = '0;
              line_nxt  = 1'b0;
            end
          endcase
        end
      end else begin
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
        line_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r     <= '0;
      bits_left_r <= '0;
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      line_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      frame_r     <= frame_nxt;
      bits_left_r <= bits_left_nxt;
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      line_r      <= line_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pin_level_r <= line_nxt;
      busy_r      <= is_busy(phase_nxt);
      rejected_r  <= rejected;
    end
  end

endmodule

`default_nettype wire
